[design/lsmd_pkg.sv]
// lsmd_pkg: shared types and constants for the line sensor majority/debounce filter.
// No dependencies.
`timescale 1ns / 1ps

package lsmd_pkg;

  localparam int ROWS     = 3;
  localparam int COLUMNS  = 5;
  localparam int CHANNELS = ROWS * COLUMNS;

  localparam int WORD_W = 16;   // raw sensor word
  localparam int CNT_W  = 9;    // per-channel ones count
  localparam int N_W    = 8;    // sample_count register
  localparam int IDX_W  = 2;    // configuration register index
  localparam int DATA_W = 8;    // configuration write data

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_FILTER_MODE  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd1;

  localparam logic [N_W-1:0] SAMPLE_COUNT_RST = 8'd4;

  typedef enum logic {
    MODE_MAJORITY = 1'b0,
    MODE_STABLE   = 1'b1
  } filter_mode_t;

  typedef logic [CHANNELS-1:0] pattern_t;

  typedef struct packed {
    filter_mode_t   mode;
    logic [N_W-1:0] sample_count;
    logic           restart;      // a register was written this cycle
  } cfg_t;

endpackage

[design/line_sensor_majority_debounce_top.sv]
// line_sensor_majority_debounce_top: majority vote / debounce filter for a
// 3 x 5 line sensor bar. Depends on lsmd_pkg, lsmd_cfg, lsmd_in_reg,
// lsmd_core, lsmd_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall / in_raw_word): one raw sensor read
//   per item; bits 14..0 are the 15 channels, bit 15 is ignored.
//   Result channel (out_valid / out_stall / out_*_row): one filtered
//   pattern per completed request, split into back, middle and front rows.
//   Config port: cfg_we, cfg_index (0 = filter mode, 1 = sample count),
//   cfg_wdata. Any write to a listed register restarts the request.
//   Write config only while the block is idle.
// Timing:
//   An accepted item sits in the input register; the vote or run check is
//   done combinationally from it, and the result is loaded into the output
//   register at an edge where that register is empty or being drained.
//   One item per cycle is accepted sustained while the result side does not
//   stall; the input register is released whenever the output register is
//   empty or being drained.
// Reset (rst_n low, synchronous): both stages empty, majority mode, sample
//   count 4, and the next item starts a new request.
// Stall: a stalled result holds its value; the item behind it waits in the
//   input register, and in_stall rises only while both stages are full.
`timescale 1ns / 1ps

module line_sensor_majority_debounce_top
  import lsmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WORD_W-1:0]  in_raw_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLUMNS-1:0] out_back_row,
  output logic [COLUMNS-1:0] out_middle_row,
  output logic [COLUMNS-1:0] out_front_row,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [DATA_W-1:0]  cfg_wdata
);

  cfg_t     cfg;
  logic     can_load;     // output register can take a result
  logic     held_valid;
  pattern_t held_pattern;
  logic     take;
  logic     res_valid;
  pattern_t res_pattern;

  // the held item is consumed whenever the result side has room, whether
  // or not it completes a request
  assign take = held_valid && can_load;

  lsmd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsmd_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_raw_word  (in_raw_word),
    .advance      (can_load),
    .held_valid   (held_valid),
    .held_pattern (held_pattern)
  );

  lsmd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .take        (take),
    .pattern     (held_pattern),
    .res_valid   (res_valid),
    .res_pattern (res_pattern)
  );

  lsmd_out_reg u_out_reg (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_pattern    (res_pattern),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_back_row   (out_back_row),
    .out_middle_row (out_middle_row),
    .out_front_row  (out_front_row)
  );

endmodule

[design/lsmd_cfg.sv]
// lsmd_cfg: configuration registers (filter mode, sample count) and restart pulse.
// Depends on lsmd_pkg.
`timescale 1ns / 1ps

module lsmd_cfg
  import lsmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_wdata,
  output cfg_t              cfg
);

  filter_mode_t   mode_r;
  logic [N_W-1:0] count_r;
  logic           hit_mode;
  logic           hit_count;

  assign hit_mode  = cfg_we && (cfg_index == CFG_FILTER_MODE);
  assign hit_count = cfg_we && (cfg_index == CFG_SAMPLE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_MAJORITY;
      count_r <= SAMPLE_COUNT_RST;
    end else begin
      if (hit_mode) begin
        mode_r <= filter_mode_t'(cfg_wdata[0]);
      end
      if (hit_count) begin
        count_r <= cfg_wdata[N_W-1:0];
      end
    end
  end

  assign cfg.mode         = mode_r;
  assign cfg.sample_count = count_r;
  assign cfg.restart      = hit_mode || hit_count;

endmodule

[design/lsmd_in_reg.sv]
// lsmd_in_reg: input register stage; holds one raw sensor item.
// Depends on lsmd_pkg.
`timescale 1ns / 1ps

module lsmd_in_reg
  import lsmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] in_raw_word,
  input  logic              advance,    // downstream takes the held item
  output logic              held_valid,
  output pattern_t          held_pattern
);

  logic     valid_r;
  pattern_t pattern_r;

  assign in_stall = valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // bit 15 is dropped here and never reaches the filter
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pattern_r <= in_raw_word[CHANNELS-1:0];
    end
  end

  assign held_valid   = valid_r;
  assign held_pattern = pattern_r;

endmodule

[design/lsmd_core.sv]
// lsmd_core: filter state (counts, previous pattern, run length) and the
// per-item decision. Depends on lsmd_pkg.
`timescale 1ns / 1ps

module lsmd_core
  import lsmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     take,        // held item is consumed this cycle
  input  pattern_t pattern,
  output logic     res_valid,
  output pattern_t res_pattern
);

  logic [CHANNELS-1:0][CNT_W-1:0] cnt_r, cnt_nxt;
  logic [N_W-1:0] seen_r, seen_nxt;
  logic [N_W-1:0] run_r, run_nxt;
  pattern_t       prev_r;
  logic           first_r;
  pattern_t       vote;
  logic [CNT_W:0] total;
  logic           emit;

  assign total = {2'b00, cfg.sample_count} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    for (int b = 0; b < CHANNELS; b++) begin
      if (first_r) begin
        cnt_nxt[b] = {{(CNT_W-1){1'b0}}, pattern[b]};
      end else begin
        cnt_nxt[b] = cnt_r[b] + {{(CNT_W-1){1'b0}}, pattern[b]};
      end
      vote[b] = {cnt_nxt[b], 1'b0} >= total;
    end
  end

  assign seen_nxt = first_r ? '0 : seen_r + 1'b1;

  always_comb begin
    if (first_r || (pattern != prev_r)) begin
      run_nxt = '0;
    end else begin
      run_nxt = run_r + 1'b1;
    end
  end

  always_comb begin
    unique case (cfg.mode)
      MODE_MAJORITY: begin
        emit        = seen_nxt >= cfg.sample_count;
        res_pattern = vote;
      end
      MODE_STABLE: begin
        emit        = run_nxt >= cfg.sample_count;
        res_pattern = pattern;
      end
      default: begin
        emit        = 1'b0;
        res_pattern = pattern;
      end
    endcase
  end

  assign res_valid = take && emit;

  // first_r is the only state that needs reset: every request starts by
  // overwriting counts, sample tally and run length.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (cfg.restart) begin
      first_r <= 1'b1;
    end else if (take) begin
      first_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (cfg.mode == MODE_MAJORITY) begin
        cnt_r  <= cnt_nxt;
        seen_r <= seen_nxt;
      end else begin
        run_r  <= run_nxt;
        prev_r <= pattern;
      end
    end
  end

endmodule

[design/lsmd_out_reg.sv]
// lsmd_out_reg: result register; splits the filtered pattern into its rows.
// Depends on lsmd_pkg.
`timescale 1ns / 1ps

module lsmd_out_reg
  import lsmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  pattern_t           res_pattern,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLUMNS-1:0] out_back_row,
  output logic [COLUMNS-1:0] out_middle_row,
  output logic [COLUMNS-1:0] out_front_row
);

  logic     valid_r;
  pattern_t pattern_r;

  assign can_load = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      pattern_r <= res_pattern;
    end
  end

  assign out_valid      = valid_r;
  assign out_back_row   = pattern_r[0*COLUMNS +: COLUMNS];
  assign out_middle_row = pattern_r[1*COLUMNS +: COLUMNS];
  assign out_front_row  = pattern_r[2*COLUMNS +: COLUMNS];

endmodule

[tb/line_sensor_majority_debounce_top_tb.sv]
// Self-checking bench for line_sensor_majority_debounce_top: a random burst driver,
// a stalling result sink and a cycle-free predictor of the vote / debounce filter.
// Depends on lsmd_pkg and the design sources only.
`timescale 1ns / 1ps

module line_sensor_majority_debounce_top_tb;
  import lsmd_pkg::*;

  // Indexes past the register list; writes there must change nothing.
  localparam logic [IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int WORD_TARGET = 700;

  // One filtered result; packed so a 15-bit pattern casts straight onto the rows
  // (front = bits 14..10, middle = 9..5, back = 4..0).
  typedef struct packed {
    logic [COLUMNS-1:0] front;
    logic [COLUMNS-1:0] middle;
    logic [COLUMNS-1:0] back;
  } rows_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [WORD_W-1:0]  in_raw_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COLUMNS-1:0] out_back_row;
  logic [COLUMNS-1:0] out_middle_row;
  logic [COLUMNS-1:0] out_front_row;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]  cfg_wdata = '0;

  line_sensor_majority_debounce_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_raw_word    (in_raw_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_back_row   (out_back_row),
    .out_middle_row (out_middle_row),
    .out_front_row  (out_front_row),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter predictor state (mirrors the block's registers and request state)
  // --------------------------------------------------------------------------
  filter_mode_t   flt_mode;
  logic [N_W-1:0] flt_count;                 // N
  logic [CNT_W-1:0] ones_cnt [CHANNELS];     // majority: ones per channel
  pattern_t       last_pattern;              // stable: previous sample
  logic [N_W-1:0] extra_seen;                // majority: samples after the first
  logic [N_W-1:0] same_run;                  // stable: equal comparisons in a row
  bit             fresh_request;             // next sample opens a request

  logic [WORD_W-1:0] sensor_words [$];       // items waiting for the driver
  rows_t             expected_rows [$];      // predicted results, oldest first

  int  words_sent;
  int  rows_checked;
  int  settings_written;
  int  errors;
  bit  word_taken;                           // item accepted at the last rising edge

  // Apply one accepted sensor word to the predictor; queue a result if the
  // request completes.
  task automatic filter_word(input logic [WORD_W-1:0] word);
    pattern_t pat;
    pattern_t voted;
    pat = word[CHANNELS-1:0];               // bit 15 never reaches the filter
    if (flt_mode == MODE_MAJORITY) begin
      for (int b = 0; b < CHANNELS; b++)
        ones_cnt[b] = fresh_request ? CNT_W'(pat[b]) : ones_cnt[b] + CNT_W'(pat[b]);
      extra_seen = fresh_request ? '0 : extra_seen + 1'b1;
      fresh_request = 1'b0;
      if (extra_seen >= flt_count) begin
        // 2*count >= N+1, so a tie votes 1
        for (int b = 0; b < CHANNELS; b++)
          voted[b] = {1'b0, ones_cnt[b], 1'b0} >= ({2'b0, flt_count} + 11'd1);
        expected_rows.push_back(rows_t'(voted));
        fresh_request = 1'b1;
      end
    end else begin
      if (fresh_request)
        same_run = '0;
      else if (pat == last_pattern)
        same_run = same_run + 1'b1;
      else
        same_run = '0;                       // any change restarts the run
      fresh_request = 1'b0;
      last_pattern = pat;
      if (same_run >= flt_count) begin
        expected_rows.push_back(rows_t'(pat));
        fresh_request = 1'b1;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: checks results, tracks register writes and accepted items.
  // Everything is sampled at the rising edge; inputs moved at the falling one.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    rows_t want;
    if (!rst_n) begin
      flt_mode      = MODE_MAJORITY;
      flt_count     = SAMPLE_COUNT_RST;
      for (int b = 0; b < CHANNELS; b++)
        ones_cnt[b] = '0;
      last_pattern  = '0;
      extra_seen    = '0;
      same_run      = '0;
      fresh_request = 1'b1;
      word_taken    = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("result with nothing expected: back %h middle %h front %h",
                 out_back_row, out_middle_row, out_front_row);
          errors++;
        end else begin
          want = expected_rows.pop_front();
          rows_checked++;
          if (out_back_row !== want.back) begin
            $error("back_row: expected %h, got %h", want.back, out_back_row);
            errors++;
          end
          if (out_middle_row !== want.middle) begin
            $error("middle_row: expected %h, got %h", want.middle, out_middle_row);
            errors++;
          end
          if (out_front_row !== want.front) begin
            $error("front_row: expected %h, got %h", want.front, out_front_row);
            errors++;
          end
        end
      end
      // a write to a listed register also drops the request in progress
      if (cfg_we) begin
        case (cfg_index)
          CFG_FILTER_MODE: begin
            flt_mode      = filter_mode_t'(cfg_wdata[0]);
            fresh_request = 1'b1;
          end
          CFG_SAMPLE_COUNT: begin
            flt_count     = cfg_wdata[N_W-1:0];
            fresh_request = 1'b1;
          end
          default: ;
        endcase
      end
      word_taken = in_valid && !in_stall;
      if (word_taken)
        filter_word(in_raw_word);
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Valid is held
  // with a steady word until the item is taken.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (word_taken) begin
        burst_left--;
        if (burst_left <= 0) begin
          // one gap in four is empty, so some bursts run back to back
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sensor_words.size() != 0) begin
        in_valid    <= 1'b1;
        in_raw_word <= sensor_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Sink: stall probability picked afresh at the start of each window; a third of the
  // windows never stall.
  int stall_pct  = 0;
  int stall_tick = 0;

  always @(negedge clk) begin
    if (stall_tick == 0)
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
    stall_tick = (stall_tick + 1) % 48;
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_word(input logic [WORD_W-1:0] word);
    sensor_words.push_back(word);
    words_sent++;
  endtask

  // Wait until every item is in and every result out, then let the pipe
  // (two stages) drain items that produce no result.
  task automatic settle();
    while (sensor_words.size() != 0 || in_valid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Upper bits of the mode write are junk; only bit 0 counts.
  task automatic set_filter(input filter_mode_t mode, input logic [N_W-1:0] n);
    settle();
    write_reg(CFG_FILTER_MODE, {7'($urandom()), mode});
    write_reg(CFG_SAMPLE_COUNT, n);
    settings_written++;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    filter_mode_t   mode;
    logic [N_W-1:0] n;
    logic [CHANNELS-1:0] base;
    logic [CHANNELS-1:0] flips;
    int reqs;
    int len;

    words_sent       = 0;
    rows_checked     = 0;
    settings_written = 0;
    errors           = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: majority over 5 samples, extremes and bit 15 alone.
    queue_word(16'hFFFF);
    queue_word(16'h0000);
    queue_word(16'h7FFF);
    queue_word(16'h8000);
    queue_word(16'h5555);

    // Zero count, majority: each word is its own result; bit 15 dropped.
    set_filter(MODE_MAJORITY, 8'd0);
    queue_word(16'hFFFF);
    queue_word(16'h8000);
    queue_word(16'h4001);

    // Zero count, stable: the first sample is emitted as is.
    set_filter(MODE_STABLE, 8'd0);
    queue_word(16'hAAAA);
    queue_word(16'h1234);

    // Stable, two equal compares; bit 15 toggling still counts as equal,
    // then a change mid-run restarts it.
    set_filter(MODE_STABLE, 8'd2);
    queue_word(16'h1111);
    queue_word(16'h1111);
    queue_word(16'h9111);
    queue_word(16'h2222);
    queue_word(16'h3333);
    queue_word(16'h3333);
    queue_word(16'h3333);

    // Tie over two samples votes 1 on every channel.
    set_filter(MODE_MAJORITY, 8'd1);
    queue_word(16'h7FFF);
    queue_word(16'h0000);

    // Writes to unlisted indexes leave the open request alone.
    set_filter(MODE_MAJORITY, 8'd3);
    queue_word(16'h0F0F);
    queue_word(16'h00FF);
    settle();
    write_reg(CFG_SPARE_2, 8'hFF);
    write_reg(CFG_SPARE_3, 8'h00);
    queue_word(16'h0FF0);
    queue_word(16'h7000);

    // A listed write mid-request aborts it; the next word starts over.
    queue_word(16'h7FFF);
    settle();
    write_reg(CFG_SAMPLE_COUNT, 8'd3);
    queue_word(16'h0001);
    queue_word(16'h0003);
    queue_word(16'h4007);
    queue_word(16'h000F);

    // Largest count, majority: 256 random words, counts hover at the threshold.
    set_filter(MODE_MAJORITY, 8'hFF);
    for (int s = 0; s < 256; s++)
      queue_word(16'($urandom()));

    // Largest count, stable: 256 copies of one pattern with bit 15 noise.
    set_filter(MODE_STABLE, 8'hFF);
    base = 15'($urandom());
    for (int s = 0; s < 256; s++)
      queue_word({1'($urandom()), base});

    // Random phases, mostly small counts so requests complete often.
    while (words_sent < WORD_TARGET) begin
      mode = filter_mode_t'($urandom_range(0, 1));
      n = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 6)) : 8'($urandom_range(7, 24));
      set_filter(mode, n);
      reqs = $urandom_range(2, 6);
      if (mode == MODE_MAJORITY) begin
        for (int r = 0; r < reqs; r++) begin
          base = 15'($urandom());
          for (int s = 0; s <= int'(n); s++) begin
            flips = 15'($urandom() & $urandom());   // about a quarter of the channels
            queue_word({1'($urandom()), base ^ flips});
          end
        end
        // sometimes leave a request open for the next write to abort
        if (n != 0 && $urandom_range(0, 3) == 0) begin
          len = $urandom_range(1, n);
          for (int s = 0; s < len; s++)
            queue_word(16'($urandom()));
        end
      end else begin
        for (int r = 0; r < reqs; r++) begin
          base = 15'($urandom());
          len = ($urandom_range(0, 3) != 0) ? int'(n) + 1 + $urandom_range(0, 2)
                                            : $urandom_range(1, int'(n) + 1);
          for (int s = 0; s < len; s++) begin
            // a rare single-channel glitch breaks the run
            flips = ($urandom_range(0, 9) == 0) ? 15'(1) << $urandom_range(0, 14) : '0;
            queue_word({1'($urandom()), base ^ flips});
          end
        end
      end
    end

    // Drain: wait for the last item, give the results a bounded time, then
    // let the pipe go quiet.
    while (sensor_words.size() != 0 || in_valid)
      @(posedge clk);
    for (int w = 0; w < 4000 && expected_rows.size() != 0; w++)
      @(posedge clk);
    repeat (6) @(posedge clk);
    if (expected_rows.size() != 0) begin
      $error("%0d predicted results never arrived", expected_rows.size());
      errors++;
    end

    $display("covered: %0d sensor words over %0d filter settings, %0d results checked",
             words_sent, settings_written, rows_checked);
    $display("errors: %0d", errors);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
design/lsmd_pkg.sv
design/lsmd_cfg.sv
design/lsmd_in_reg.sv
design/lsmd_core.sv
design/lsmd_out_reg.sv
design/line_sensor_majority_debounce_top.sv
tb/line_sensor_majority_debounce_top_tb.sv
